>>> src/crc8cfr_pkg.sv
// ----------------------------------------------------------------------------
// crc8cfr_pkg
// Shared types, constants and functions of the command frame receiver.
// ----------------------------------------------------------------------------
package crc8cfr_pkg;

    // Frame layout: header, first argument, second argument, CRC byte
    localparam int FRAME_BYTES = 4;
    localparam int FILL_W      = 3;

    localparam logic [7:0] DELIMITER = 8'hFF;

    // Command that carries wheel run/flip requests
    localparam logic [3:0] CMD_WHEEL_MODES = 4'd3;

    // Wheel request codes
    localparam logic [1:0] MODE_KEEP = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_FLIP = 2'd2;

    // Wheel pair argument values
    localparam logic [7:0] PAIR_RUN_RUN   = 8'd0;
    localparam logic [7:0] PAIR_RUN_FLIP  = 8'd1;
    localparam logic [7:0] PAIR_FLIP_RUN  = 8'd2;
    localparam logic [7:0] PAIR_FLIP_FLIP = 8'd3;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [1:0] left;
        logic [1:0] right;
    } pair_mode_t;

    // One result transaction
    typedef struct packed {
        logic       crc_ok;
        logic       drive_enable;
        logic       cameras_enable;
        logic       radio_enable;
        logic       sensors_enable;
        logic [3:0] command_code;
        logic [7:0] arg_first;
        logic [7:0] arg_second;
        logic [1:0] front_left_mode;
        logic [1:0] front_right_mode;
        logic [1:0] back_left_mode;
        logic [1:0] back_right_mode;
    } result_t;

    // Status of the frame window towards the decoder
    typedef struct packed {
        logic  frame_end;
        logic  crc_match;
        byte_t header;
        byte_t arg_a;
        byte_t arg_b;
    } frame_t;

    // Nibble lookup for the CRC-8
    localparam byte_t NIB_TABLE [16] = '{
        8'h00, 8'h1C, 8'h38, 8'h24,
        8'h70, 8'h6C, 8'h48, 8'h54,
        8'hE0, 8'hFC, 8'hD8, 8'hC4,
        8'h90, 8'h8C, 8'hA8, 8'hB4
    };

    function automatic byte_t crc_nibble(input byte_t crc, input logic [3:0] nib);
        return {4'h0, crc[7:4]} ^ NIB_TABLE[crc[3:0]] ^ NIB_TABLE[nib];
    endfunction

    // CRC over header and both arguments, low nibble first, zero start
    function automatic byte_t crc_three(input byte_t b0, input byte_t b1, input byte_t b2);
        byte_t crc;
        crc = 8'h00;
        crc = crc_nibble(crc, b0[3:0]);
        crc = crc_nibble(crc, b0[7:4]);
        crc = crc_nibble(crc, b1[3:0]);
        crc = crc_nibble(crc, b1[7:4]);
        crc = crc_nibble(crc, b2[3:0]);
        crc = crc_nibble(crc, b2[7:4]);
        return crc;
    endfunction

    // Wheel pair request; the front pair leaves its right wheel alone for flip/run
    function automatic pair_mode_t pair_modes(input byte_t arg, input logic front);
        pair_mode_t m;
        m.left  = MODE_KEEP;
        m.right = MODE_KEEP;
        unique case (arg)
            PAIR_RUN_RUN:
            begin
                m.left  = MODE_RUN;
                m.right = MODE_RUN;
            end
            PAIR_RUN_FLIP:
            begin
                m.left  = MODE_RUN;
                m.right = MODE_FLIP;
            end
            PAIR_FLIP_RUN:
            begin
                m.left  = MODE_FLIP;
                m.right = front ? MODE_KEEP : MODE_RUN;
            end
            PAIR_FLIP_FLIP:
            begin
                m.left  = MODE_FLIP;
                m.right = MODE_FLIP;
            end
            default:
            begin
                m.left  = MODE_KEEP;
                m.right = MODE_KEEP;
            end
        endcase
        return m;
    endfunction

endpackage

>>> src/crc8cfr_window.sv
// ----------------------------------------------------------------------------
// crc8cfr_window
// Byte window with saturating fill count; detects frame end and checks CRC.
// ----------------------------------------------------------------------------
module crc8cfr_window (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                strobe,
    input  crc8cfr_pkg::byte_t  data,
    output crc8cfr_pkg::frame_t frame
);
    import crc8cfr_pkg::*;

    byte_t             window_reg [FRAME_BYTES];
    byte_t             window_next [FRAME_BYTES];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    logic full;
    logic clear;

    // Frame status from the current window and the byte on offer
    assign full            = (fill_reg == FILL_W'(FRAME_BYTES));
    assign frame.frame_end = (data == DELIMITER) && full;
    assign frame.crc_match =
        (crc_three(window_reg[0], window_reg[1], window_reg[2]) == window_reg[FRAME_BYTES-1]);
    assign frame.header    = window_reg[0];
    assign frame.arg_a     = window_reg[1];
    assign frame.arg_b     = window_reg[2];

    assign clear = frame.frame_end && frame.crc_match;

    // Shift in, or clear after a good frame
    always_comb
    begin
        window_next = window_reg;
        fill_next   = fill_reg;
        if (strobe)
        begin
            if (clear)
            begin
                for (int i = 0; i < FRAME_BYTES; i++)
                begin
                    window_next[i] = 8'h00;
                end
                fill_next = '0;
            end
            else
            begin
                for (int i = 0; i < FRAME_BYTES - 1; i++)
                begin
                    window_next[i] = window_reg[i+1];
                end
                window_next[FRAME_BYTES-1] = data;
                if (!full)
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                window_reg[i] <= 8'h00;
            end
            fill_reg <= '0;
        end
        else
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

>>> src/crc8cfr_decode.sv
// ----------------------------------------------------------------------------
// crc8cfr_decode
// Turns a checked frame into a result: enables, command, arguments, wheels.
// ----------------------------------------------------------------------------
module crc8cfr_decode (
    input  crc8cfr_pkg::frame_t  frame,
    output crc8cfr_pkg::result_t result
);
    import crc8cfr_pkg::*;

    pair_mode_t front;
    pair_mode_t back;
    logic       wheel_cmd;

    assign front     = pair_modes(frame.arg_a, 1'b1);
    assign back      = pair_modes(frame.arg_b, 1'b0);
    assign wheel_cmd = (frame.header[3:0] == CMD_WHEEL_MODES);

    // A mismatch gives an all-zero result
    always_comb
    begin
        result = '0;
        if (frame.crc_match)
        begin
            result.crc_ok         = 1'b1;
            result.drive_enable   = ~frame.header[7];
            result.cameras_enable = ~frame.header[6];
            result.radio_enable   = ~frame.header[5];
            result.sensors_enable = ~frame.header[4];
            result.command_code   = frame.header[3:0];
            result.arg_first      = frame.arg_a;
            result.arg_second     = frame.arg_b;
            if (wheel_cmd)
            begin
                result.front_left_mode  = front.left;
                result.front_right_mode = front.right;
                result.back_left_mode   = back.left;
                result.back_right_mode  = back.right;
            end
        end
    end

endmodule

>>> src/crc8_command_frame_receiver.sv
// ----------------------------------------------------------------------------
// crc8_command_frame_receiver
// Receives a byte stream, frames on the delimiter byte, checks CRC-8 and
// decodes the command frame.
//
//   channel  dir  handshake            payload
//   input    in   in_valid / in_stall  rx_byte
//   output   out  out_valid/ out_stall crc_ok .. back_right_mode
//
// One byte per cycle sustained unless a frame end waits on a stalled output;
// bytes pass the input register, then window/CRC/decode to the result register.
// Reset clears the window, fill count and both valid flags.
// Bytes that give no result never wait on the output side; a delimiter that
// ends a frame waits only while the result register is full and stalled.
// ----------------------------------------------------------------------------
module crc8_command_frame_receiver (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       crc_ok,
    output logic       drive_enable,
    output logic       cameras_enable,
    output logic       radio_enable,
    output logic       sensors_enable,
    output logic [3:0] command_code,
    output logic [7:0] arg_first,
    output logic [7:0] arg_second,
    output logic [1:0] front_left_mode,
    output logic [1:0] front_right_mode,
    output logic [1:0] back_left_mode,
    output logic [1:0] back_right_mode
);
    import crc8cfr_pkg::*;

    logic    s1_valid_reg;
    logic    s1_valid_next;
    byte_t   s1_byte_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;
    result_t result_next;

    frame_t  frame;
    logic    out_free;
    logic    s1_go;
    logic    in_take;

    crc8cfr_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .strobe (s1_go),
        .data   (s1_byte_reg),
        .frame  (frame)
    );

    crc8cfr_decode u_decode (
        .frame  (frame),
        .result (result_next)
    );

    // Flow control: only a frame end needs the result register
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && (!frame.frame_end || out_free);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go && frame.frame_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (s1_go && frame.frame_end)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign crc_ok           = result_reg.crc_ok;
    assign drive_enable     = result_reg.drive_enable;
    assign cameras_enable   = result_reg.cameras_enable;
    assign radio_enable     = result_reg.radio_enable;
    assign sensors_enable   = result_reg.sensors_enable;
    assign command_code     = result_reg.command_code;
    assign arg_first        = result_reg.arg_first;
    assign arg_second       = result_reg.arg_second;
    assign front_left_mode  = result_reg.front_left_mode;
    assign front_right_mode = result_reg.front_right_mode;
    assign back_left_mode   = result_reg.back_left_mode;
    assign back_right_mode  = result_reg.back_right_mode;

endmodule

>>> test/crc8_command_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// crc8_command_frame_receiver_tb
// Self-checking bench for the CRC-8 command frame receiver. A short table of
// directed bytes covers the reset window, the all-zero frame, a CRC reject,
// back-to-back delimiters and the wheel-mode decode. Random frame traffic
// follows. Good frames, corrupted CRCs, short frames and noise are mixed, under
// three idling mixes and one long output hold-off. Every result transaction is
// compared field by field with a predictor that runs alongside the stimulus.
// ----------------------------------------------------------------------------
module crc8_command_frame_receiver_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import crc8cfr_pkg::*;

    // Random traffic size per idling phase
    localparam int unsigned PHASE_ITEMS = 650;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_LIMIT = 50000;
    localparam int unsigned MAX_PRINTS  = 100;

    // Nibble lookup for the frame CRC-8
    localparam byte_t FRAME_NIB [16] = '{
        8'h00, 8'h1C, 8'h38, 8'h24,
        8'h70, 8'h6C, 8'h48, 8'h54,
        8'hE0, 8'hFC, 8'hD8, 8'hC4,
        8'h90, 8'h8C, 8'hA8, 8'hB4
    };

    // Results typed straight into the table (crc_ok, four enables, rest zero)
    localparam result_t RES_NONE       = '0;
    localparam result_t RES_CRC_REJECT = '0;
    localparam result_t RES_ZERO_FRAME = {5'b11111, 28'd0};

    typedef enum logic {ROW_BYTE, ROW_CRC} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        byte_t     value;
        logic      typed_in;
        result_t   want;
    } stim_row_t;

    localparam int DIRECTED_LEN = 27;

    localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        // delimiter straight after reset: window short, no result
        '{ROW_BYTE, 8'hFF, 1'b0, RES_NONE},
        // all-zero frame: CRC of zeros is zero, every enable active
        '{ROW_BYTE, 8'h00, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'h00, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'h00, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'h00, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'hFF, 1'b1, RES_ZERO_FRAME},
        // wrong CRC byte: reject, delimiter kept in the window
        '{ROW_BYTE, 8'h00, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'h00, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'h00, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'h01, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'hFF, 1'b1, RES_CRC_REJECT},
        // second delimiter checks a window that holds the first
        '{ROW_BYTE, 8'hFF, 1'b0, RES_NONE},
        // wheel modes, flip/run on both pairs
        '{ROW_BYTE, 8'h03, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'h02, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'h02, 1'b0, RES_NONE},
        '{ROW_CRC,  8'h00, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'hFF, 1'b0, RES_NONE},
        // wheel modes with every enable off: run/flip front, flip/flip back
        '{ROW_BYTE, 8'hF3, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'h01, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'h03, 1'b0, RES_NONE},
        '{ROW_CRC,  8'h00, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'hFF, 1'b0, RES_NONE},
        // other command, argument extremes: no wheel modes
        '{ROW_BYTE, 8'h70, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'hFE, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'h00, 1'b0, RES_NONE},
        '{ROW_CRC,  8'h00, 1'b0, RES_NONE},
        '{ROW_BYTE, 8'hFF, 1'b0, RES_NONE}
    };

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       crc_ok;
    logic       drive_enable;
    logic       cameras_enable;
    logic       radio_enable;
    logic       sensors_enable;
    logic [3:0] command_code;
    logic [7:0] arg_first;
    logic [7:0] arg_second;
    logic [1:0] front_left_mode;
    logic [1:0] front_right_mode;
    logic [1:0] back_left_mode;
    logic [1:0] back_right_mode;

    // Predictor copy of the receive window
    byte_t       rx_window [FRAME_BYTES];
    int unsigned rx_fill;

    result_t     frames_due [$];

    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned hold_request  = 0;
    int unsigned hold_left     = 0;

    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned frames_matched = 0;
    int unsigned frames_refused = 0;
    int unsigned wheel_frames   = 0;
    int unsigned mismatch_count = 0;

    result_t     got_frame;
    result_t     want_frame;

    crc8_command_frame_receiver u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .crc_ok           (crc_ok),
        .drive_enable     (drive_enable),
        .cameras_enable   (cameras_enable),
        .radio_enable     (radio_enable),
        .sensors_enable   (sensors_enable),
        .command_code     (command_code),
        .arg_first        (arg_first),
        .arg_second       (arg_second),
        .front_left_mode  (front_left_mode),
        .front_right_mode (front_right_mode),
        .back_left_mode   (back_left_mode),
        .back_right_mode  (back_right_mode)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d transactions still expected", frames_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic byte_t nib_fold(input byte_t crc, input logic [3:0] nib);
        return {4'h0, crc[7:4]} ^ FRAME_NIB[crc[3:0]] ^ FRAME_NIB[nib];
    endfunction

    // Low nibble first, zero start
    function automatic byte_t frame_crc(input byte_t hdr, input byte_t a1, input byte_t a2);
        byte_t crc;
        crc = 8'h00;
        crc = nib_fold(crc, hdr[3:0]);
        crc = nib_fold(crc, hdr[7:4]);
        crc = nib_fold(crc, a1[3:0]);
        crc = nib_fold(crc, a1[7:4]);
        crc = nib_fold(crc, a2[3:0]);
        crc = nib_fold(crc, a2[7:4]);
        return crc;
    endfunction

    // Front right is left alone on a flip/run request
    function automatic pair_mode_t wheel_pair(input byte_t arg, input logic front);
        pair_mode_t m;
        m = '{left: MODE_KEEP, right: MODE_KEEP};
        unique case (arg)
            PAIR_RUN_RUN:   m = '{left: MODE_RUN,  right: MODE_RUN};
            PAIR_RUN_FLIP:  m = '{left: MODE_RUN,  right: MODE_FLIP};
            PAIR_FLIP_RUN:  m = '{left: MODE_FLIP, right: front ? MODE_KEEP : MODE_RUN};
            PAIR_FLIP_FLIP: m = '{left: MODE_FLIP, right: MODE_FLIP};
            default:        m = '{left: MODE_KEEP, right: MODE_KEEP};
        endcase
        return m;
    endfunction

    task automatic window_shift(input byte_t b);
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            rx_window[i] = rx_window[i + 1];
        rx_window[FRAME_BYTES - 1] = b;
        if (rx_fill < FRAME_BYTES)
            rx_fill++;
    endtask

    task automatic frame_predict(input byte_t b, output bit has_result, output result_t r);
        pair_mode_t front;
        pair_mode_t back;
        r          = '0;
        has_result = 1'b0;
        // data byte, or delimiter with a short window
        if (b != DELIMITER || rx_fill < FRAME_BYTES)
        begin
            window_shift(b);
            return;
        end
        has_result = 1'b1;
        // CRC reject: all-zero result, delimiter goes in as data
        if (frame_crc(rx_window[0], rx_window[1], rx_window[2]) != rx_window[3])
        begin
            window_shift(b);
            return;
        end
        r.crc_ok         = 1'b1;
        r.drive_enable   = ~rx_window[0][7];
        r.cameras_enable = ~rx_window[0][6];
        r.radio_enable   = ~rx_window[0][5];
        r.sensors_enable = ~rx_window[0][4];
        r.command_code   = rx_window[0][3:0];
        r.arg_first      = rx_window[1];
        r.arg_second     = rx_window[2];
        if (r.command_code == CMD_WHEEL_MODES)
        begin
            front = wheel_pair(rx_window[1], 1'b1);
            back  = wheel_pair(rx_window[2], 1'b0);
            r.front_left_mode  = front.left;
            r.front_right_mode = front.right;
            r.back_left_mode   = back.left;
            r.back_right_mode  = back.right;
        end
        // good frame empties the window
        for (int i = 0; i < FRAME_BYTES; i++)
            rx_window[i] = 8'h00;
        rx_fill = 0;
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic note_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            note_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                    results_seen, name, got, want));
    endtask

    task automatic compare_frame(input result_t got, input result_t want);
        check_field("crc_ok",           8'(got.crc_ok),           8'(want.crc_ok));
        check_field("drive_enable",     8'(got.drive_enable),     8'(want.drive_enable));
        check_field("cameras_enable",   8'(got.cameras_enable),   8'(want.cameras_enable));
        check_field("radio_enable",     8'(got.radio_enable),     8'(want.radio_enable));
        check_field("sensors_enable",   8'(got.sensors_enable),   8'(want.sensors_enable));
        check_field("command_code",     8'(got.command_code),     8'(want.command_code));
        check_field("arg_first",        got.arg_first,            want.arg_first);
        check_field("arg_second",       got.arg_second,           want.arg_second);
        check_field("front_left_mode",  8'(got.front_left_mode),  8'(want.front_left_mode));
        check_field("front_right_mode", 8'(got.front_right_mode), 8'(want.front_right_mode));
        check_field("back_left_mode",   8'(got.back_left_mode),   8'(want.back_left_mode));
        check_field("back_right_mode",  8'(got.back_right_mode),  8'(want.back_right_mode));
    endtask

    // Result monitor: a transaction is taken when valid and not stalled
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_frame = {crc_ok, drive_enable, cameras_enable, radio_enable,
                         sensors_enable, command_code, arg_first, arg_second,
                         front_left_mode, front_right_mode, back_left_mode,
                         back_right_mode};
            if (frames_due.size() == 0)
                note_mismatch($sformatf("result with nothing expected: %h", got_frame));
            else
            begin
                want_frame = frames_due.pop_front();
                compare_frame(got_frame, want_frame);
            end
            if (got_frame.crc_ok === 1'b1)
                frames_matched++;
            else
                frames_refused++;
            if (got_frame.crc_ok === 1'b1 && got_frame.command_code == CMD_WHEEL_MODES)
                wheel_frames++;
            results_seen++;
        end
    end

    // Output side: random stall, or a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_request != 0)
            begin
                hold_left    = hold_request - 1;
                hold_request = 0;
                out_stall   <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // One input transaction, with optional typed-in result
    task automatic put_byte(input byte_t b, input logic typed_in, input result_t typed_res);
        bit      has_result;
        result_t r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        frame_predict(b, has_result, r);
        if (typed_in)
        begin
            if (!has_result)
                note_mismatch($sformatf("table row %0d expects a result", items_sent));
            r          = typed_res;
            has_result = 1'b1;
        end
        if (has_result)
            frames_due = {frames_due, r};
    endtask

    // Sender pause until every expected result has arrived or the limit runs out
    task automatic drain_results(input int unsigned limit);
        int unsigned waited;
        waited = 0;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (frames_due.size() != 0 && waited < limit);
        if (frames_due.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", frames_due.size()));
    endtask

    function automatic byte_t pick_arg();
        if ($urandom_range(1) == 0)
            return byte_t'($urandom_range(4));
        return byte_t'($urandom_range(255));
    endfunction

    // A random burst: mostly well-formed frames, some short, noisy or broken
    task automatic send_frame_traffic();
        int unsigned roll;
        int unsigned n;
        byte_t       hdr;
        byte_t       a1;
        byte_t       a2;
        byte_t       crc;
        roll = $urandom_range(99);
        hdr  = byte_t'($urandom_range(255));
        if ($urandom_range(99) < 40)
            hdr[3:0] = CMD_WHEEL_MODES;
        a1  = pick_arg();
        a2  = pick_arg();
        crc = frame_crc(hdr, a1, a2);
        if (roll < 70)
        begin
            // well-formed frame, CRC corrupted now and then
            if ($urandom_range(99) < 15)
                crc = crc ^ byte_t'($urandom_range(255, 1));
            put_byte(hdr, 1'b0, RES_NONE);
            put_byte(a1,  1'b0, RES_NONE);
            put_byte(a2,  1'b0, RES_NONE);
            put_byte(crc, 1'b0, RES_NONE);
            put_byte(DELIMITER, 1'b0, RES_NONE);
        end
        else if (roll < 80)
        begin
            // short frame
            n = $urandom_range(2);
            for (int i = 0; i < n; i++)
                put_byte(byte_t'($urandom_range(255)), 1'b0, RES_NONE);
            put_byte(DELIMITER, 1'b0, RES_NONE);
        end
        else if (roll < 90)
        begin
            // noise with the odd delimiter
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++)
                put_byte(($urandom_range(7) == 0) ? DELIMITER : byte_t'($urandom_range(255)),
                         1'b0, RES_NONE);
        end
        else
        begin
            // good frame with missing or doubled delimiter
            put_byte(hdr, 1'b0, RES_NONE);
            put_byte(a1,  1'b0, RES_NONE);
            put_byte(a2,  1'b0, RES_NONE);
            put_byte(crc, 1'b0, RES_NONE);
            if ($urandom_range(1) == 0)
            begin
                put_byte(DELIMITER, 1'b0, RES_NONE);
                put_byte(DELIMITER, 1'b0, RES_NONE);
            end
        end
    endtask

    // Main sequence
    initial
    begin
        byte_t recent [3];
        byte_t b;

        for (int i = 0; i < FRAME_BYTES; i++)
            rx_window[i] = 8'h00;
        rx_fill = 0;
        recent  = '{8'h00, 8'h00, 8'h00};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        for (int row = 0; row < DIRECTED_LEN; row++)
        begin
            if (DIRECTED_ROWS[row].kind == ROW_CRC)
                b = frame_crc(recent[0], recent[1], recent[2]);
            else
                b = DIRECTED_ROWS[row].value;
            put_byte(b, DIRECTED_ROWS[row].typed_in, DIRECTED_ROWS[row].want);
            recent[0] = recent[1];
            recent[1] = recent[2];
            recent[2] = b;
        end
        drain_results(DRAIN_LIMIT);

        // random traffic under three idling mixes
        for (int phase = 0; phase < 3; phase++)
        begin
            unique case (phase)
                0:
                begin
                    src_idle_pct  = 36;
                    snk_stall_pct = 69;
                end
                1:
                begin
                    src_idle_pct  = 69;
                    snk_stall_pct = 36;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                    // long hold-off so the result register backs up the input
                    hold_request  = HOLD_CYCLES;
                end
            endcase
            while (items_sent < DIRECTED_LEN + PHASE_ITEMS * (phase + 1))
                send_frame_traffic();
            drain_results(DRAIN_LIMIT);
        end

        repeat (10) @(posedge clk);

        $display("Sent %0d bytes; %0d results checked (%0d frames accepted, %0d refused)",
                 items_sent, results_seen, frames_matched, frames_refused);
        $display("Wheel-mode frames %0d; mismatches %0d", wheel_frames, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/crc8cfr_pkg.sv
src/crc8cfr_window.sv
src/crc8cfr_decode.sv
src/crc8_command_frame_receiver.sv
test/crc8_command_frame_receiver_tb.sv
